>>> hdl/lcbp_pkg.sv
// ----------------------------------------------------------------------------
// Lane change planner package
// Shared widths, register indexes and mode codes.
// ----------------------------------------------------------------------------
package lcbp_pkg;

    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 16;

    localparam logic [CfgIdxWidth-1:0] CFG_FRONT_GAP     = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_REAR_GAP      = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_SIDE_REAR_GAP = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_AHEAD_GAP     = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_TARGET_SPEED  = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CFG_MIN_SPEED     = 3'd5;
    localparam logic [CfgIdxWidth-1:0] CFG_SPEED_STEP    = 3'd6;
    localparam logic [CfgIdxWidth-1:0] CFG_CENTER_TOL    = 3'd7;

    localparam logic [2:0] MODE_FORWARD    = 3'd0;
    localparam logic [2:0] MODE_PREP_LEFT  = 3'd1;
    localparam logic [2:0] MODE_PREP_RIGHT = 3'd2;
    localparam logic [2:0] MODE_CHG_LEFT   = 3'd3;
    localparam logic [2:0] MODE_CHG_RIGHT  = 3'd4;

    // Width of vx^2 + vy^2.
    localparam int SqWidth  = 32;
    localparam int SpdWidth = 16;

endpackage

>>> hdl/lcbp_isqrt.sv
// ----------------------------------------------------------------------------
// Lane change planner square root
// Bit-pair restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lcbp_isqrt
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lcbp_pkg::SqWidth-1:0]   radicand,
    output logic                           done,
    output logic [lcbp_pkg::SpdWidth-1:0]  root
);
    import lcbp_pkg::*;

    localparam int CntWidth = $clog2(SpdWidth + 1);

    logic [SqWidth-1:0]  rem_reg, rem_next;
    logic [SqWidth-1:0]  rad_reg, rad_next;
    logic [SpdWidth-1:0] root_reg, root_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SqWidth+1:0]  trial;
    logic [SqWidth+1:0]  shifted;

    // One step: bring down two radicand bits and try to subtract 4r+1.
    always_comb
    begin
        shifted   = {rem_reg, rad_reg[SqWidth-1 -: 2]};
        trial     = {{(SqWidth-SpdWidth){1'b0}}, root_reg, 2'b01};
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            rad_next  = radicand;
            root_next = '0;
            cnt_next  = CntWidth'(SpdWidth);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SqWidth-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = SqWidth'(shifted - trial);
                root_next = {root_reg[SpdWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next  = SqWidth'(shifted);
                root_next = {root_reg[SpdWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CntWidth'(1);
            if (cnt_reg == CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> hdl/lane_change_behaviour_planner_unit.sv
// A vehicle report keeps the input stalled while it is in work: the two
// squares one after the other on one shared multiplier, the bit-serial
// square root (16 steps, then the root is handed over while path_points
// times speed is registered), one reciprocal multiply that estimates the
// divide by fifty from below, compare and subtract steps that raise the
// estimate, and a last step to compare and set the occupancy flags. A decide
// item keeps the input stalled until its result is registered, which waits
// until an earlier result has been taken, and produces one result item held
// in an output register until it is taken; reports produce no result. One
// item is in work at a time, and the next item can be accepted as soon as
// the stall ends.
// ----------------------------------------------------------------------------
// Lane change behavior planner
// Occupancy flags from vehicle reports and a five-mode lane change machine.
// ----------------------------------------------------------------------------
module lane_change_behaviour_planner_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [22:0]                        obj_s,
    input  logic signed [13:0]                 obj_d,
    input  logic signed [15:0]                 obj_vx,
    input  logic signed [15:0]                 obj_vy,
    input  logic [22:0]                        ego_s,
    input  logic signed [13:0]                 ego_d,
    input  logic [5:0]                         path_points,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         mode,
    output logic [1:0]                         lane,
    output logic [15:0]                        ref_speed,
    input  logic                               cfg_we,
    input  logic [lcbp_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [lcbp_pkg::CfgDataWidth-1:0]  cfg_data
);
    import lcbp_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SQX   = 8'b0000_0010,
        ST_SQY   = 8'b0000_0100,
        ST_ROOT  = 8'b0000_1000,
        ST_PROJ  = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_FLAGS = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    // Configuration registers.
    logic [15:0] front_gap_reg, rear_gap_reg, side_rear_gap_reg, ahead_gap_reg;
    logic [15:0] target_speed_reg, min_speed_reg;
    logic [11:0] speed_step_reg;
    logic [9:0]  center_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_gap_reg     <= 16'd7680;
            rear_gap_reg      <= 16'd1280;
            side_rear_gap_reg <= 16'd512;
            ahead_gap_reg     <= 16'd12800;
            target_speed_reg  <= 16'd49500;
            min_speed_reg     <= 16'd10000;
            speed_step_reg    <= 12'd224;
            center_tol_reg    <= 10'd26;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRONT_GAP:     front_gap_reg     <= cfg_data;
                CFG_REAR_GAP:      rear_gap_reg      <= cfg_data;
                CFG_SIDE_REAR_GAP: side_rear_gap_reg <= cfg_data;
                CFG_AHEAD_GAP:     ahead_gap_reg     <= cfg_data;
                CFG_TARGET_SPEED:  target_speed_reg  <= cfg_data;
                CFG_MIN_SPEED:     min_speed_reg     <= cfg_data;
                CFG_SPEED_STEP:    speed_step_reg    <= cfg_data[11:0];
                CFG_CENTER_TOL:    center_tol_reg    <= cfg_data[9:0];
                default:           ;
            endcase
        end
    end

    state_t      state_reg, state_next;
    logic [9:0]  flags_reg, flags_next;
    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  lane_reg, lane_next;
    logic [15:0] speed_reg, speed_next;
    logic        ovalid_reg, ovalid_next;

    // Item payload.
    logic [22:0]        os_reg, es_reg;
    logic signed [13:0] d_reg;
    logic signed [13:0] ed_reg;
    logic signed [15:0] vx_reg, vy_reg;
    logic [5:0]         pp_reg;
    logic [31:0]        acc_reg, acc_next;
    logic [31:0]        prod_reg;
    logic [21:0]        proj_reg, proj_next;

    // Shared multiplier: 17x17 signed.
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic              sq_start, sq_done;
    logic [15:0]       sq_root;

    // The root starts on the full sum, which is ready in the same cycle.
    lcbp_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (acc_next),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Lane tests on the reported lateral position.
    function automatic logic in_lane_f(input logic signed [13:0] d,
                                       input logic signed [3:0] k);
        logic signed [15:0] lo;
        begin
            lo = 16'(k) * 16'sd1024;
            in_lane_f = (16'(d) > lo) && (16'(d) < lo + 16'sd1024);
        end
    endfunction

    // Flag update for one report.
    logic [23:0] ps;
    logic        ps_gt, ps_lt;
    logic [23:0] fwd, bwd;
    logic        ahead_fg, side;
    logic signed [3:0] cur;
    logic [9:0]  rep_flags;

    always_comb
    begin
        ps       = 24'(os_reg) + 24'(proj_reg);
        ps_gt    = ps > 24'(es_reg);
        ps_lt    = ps < 24'(es_reg);
        fwd      = ps - 24'(es_reg);
        bwd      = 24'(es_reg) - ps;
        ahead_fg = ps_gt && (fwd < 24'(front_gap_reg));
        side     = ahead_fg || (!ps_gt && (bwd < 24'(side_rear_gap_reg)));
        cur      = 4'(lane_reg);
        rep_flags = flags_reg;
        if (in_lane_f(d_reg, cur))
        begin
            if (ahead_fg)
                rep_flags[0] = 1'b1;
            else if (ps_lt && (bwd < 24'(rear_gap_reg)))
                rep_flags[1] = 1'b1;
        end
        else if (in_lane_f(d_reg, cur - 4'sd1))
        begin
            if (side)
                rep_flags[2] = 1'b1;
        end
        else if (in_lane_f(d_reg, cur + 4'sd1))
        begin
            if (side)
                rep_flags[3] = 1'b1;
        end
        for (int k = 0; k < 3; k++)
        begin
            if (in_lane_f(d_reg, 4'(k)) && ps_gt)
            begin
                if (fwd < 24'(ahead_gap_reg))
                    rep_flags[4+k] = 1'b1;
                if (fwd < 24'(front_gap_reg))
                    rep_flags[7+k] = 1'b1;
            end
        end
    end

    // Speed rules.
    logic [15:0] spd_up, spd_dn;
    logic [16:0] up_sum;
    always_comb
    begin
        up_sum = 17'(speed_reg) + 17'(speed_step_reg);
        spd_up = speed_reg;
        if (speed_reg < target_speed_reg)
            spd_up = up_sum[16] ? 16'hFFFF : up_sum[15:0];
        spd_dn = speed_reg;
        if (speed_reg > min_speed_reg)
            spd_dn = (speed_reg > 16'(speed_step_reg)) ?
                     speed_reg - 16'(speed_step_reg) : 16'd0;
    end

    // Decision on the collected flags.
    logic [2:0]  dec_mode;
    logic [1:0]  dec_lane;
    logic [15:0] dec_speed;
    logic        f_front, f_back, f_left, f_right, busy;
    logic signed [15:0] off, off_abs;
    logic        centered;

    always_comb
    begin
        f_front = flags_reg[0];
        f_back  = flags_reg[1];
        f_left  = flags_reg[2];
        f_right = flags_reg[3];
        off     = 16'(ed_reg) - (16'sd512 + 16'sd1024 * 16'(lane_reg));
        off_abs = off[15] ? -off : off;
        centered = off_abs < 16'(center_tol_reg);
        dec_mode  = mode_reg;
        dec_lane  = lane_reg;
        dec_speed = speed_reg;
        busy      = 1'b0;
        case (mode_reg)
            MODE_PREP_LEFT, MODE_PREP_RIGHT:
            begin
                if ((mode_reg == MODE_PREP_LEFT) ? f_left : f_right)
                    dec_speed = (f_back && !f_front) ? spd_up : spd_dn;
                else if (mode_reg == MODE_PREP_LEFT)
                begin
                    if (lane_reg > 2'd0)
                        dec_lane = lane_reg - 2'd1;
                    dec_mode = MODE_CHG_LEFT;
                end
                else
                begin
                    if (lane_reg < 2'd2)
                        dec_lane = lane_reg + 2'd1;
                    dec_mode = MODE_CHG_RIGHT;
                end
            end
            MODE_CHG_LEFT, MODE_CHG_RIGHT:
            begin
                if (centered)
                    dec_mode = MODE_FORWARD;
                dec_speed = f_front ? spd_dn : spd_up;
            end
            default:
            begin
                dec_mode = MODE_FORWARD;
                if (!f_front)
                    dec_speed = spd_up;
                else if (lane_reg > 2'd0 && !f_left)
                begin
                    busy = flags_reg[4 + 32'(lane_reg) - 1];
                    dec_mode = (f_right || !busy || lane_reg == 2'd2) ?
                               MODE_PREP_LEFT : MODE_PREP_RIGHT;
                end
                else if (lane_reg < 2'd2 && !f_right)
                begin
                    busy = flags_reg[4 + 32'(lane_reg) + 1];
                    dec_mode = (f_left || !busy || lane_reg == 2'd0) ?
                               MODE_PREP_RIGHT : MODE_PREP_LEFT;
                end
                else
                begin
                    if (!f_back)
                        dec_speed = spd_dn;
                    if (lane_reg == 2'd0 && flags_reg[9])
                        dec_mode = MODE_PREP_RIGHT;
                    else if (lane_reg == 2'd2 && flags_reg[7])
                        dec_mode = MODE_PREP_LEFT;
                end
            end
        endcase
    end

    // Sequencer.
    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = ovalid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    logic [27:0] q_rem;

    always_comb
    begin
        state_next  = state_reg;
        flags_next  = flags_reg;
        mode_next   = mode_reg;
        lane_next   = lane_reg;
        speed_next  = speed_reg;
        ovalid_next = ovalid_reg;
        acc_next    = acc_reg;
        proj_next   = proj_reg;
        sq_start    = 1'b0;
        mul_a       = 17'(vx_reg);
        mul_b       = 17'(vx_reg);
        // Remainder of the product against the current quotient estimate.
        q_rem = 28'(prod_reg) - 28'(proj_reg) * 28'd50;
        if (out_acc)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = func ? ST_OUT : ST_SQX;
            end
            ST_SQX:
            begin
                acc_next   = 32'(mul_p);
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                mul_a      = 17'(vy_reg);
                mul_b      = 17'(vy_reg);
                acc_next   = acc_reg + 32'(mul_p);
                sq_start   = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sq_done)
                    state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                // Quotient estimate (p >> 6) * floor(2^20 / 50) >> 14, never
                // above floor(p / 50) and at most three below it.
                mul_a      = 17'(prod_reg[21:6]);
                mul_b      = 17'sd20971;
                proj_next  = 22'(mul_p >>> 14);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // Raise the quotient until the remainder is below fifty.
                if (q_rem >= 28'd50)
                    proj_next = proj_reg + 22'd1;
                else
                    state_next = ST_FLAGS;
            end
            ST_FLAGS:
            begin
                flags_next = rep_flags;
                state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_acc)
                begin
                    mode_next   = dec_mode;
                    lane_next   = dec_lane;
                    speed_next  = dec_speed;
                    flags_next  = '0;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            flags_reg  <= '0;
            mode_reg   <= MODE_FORWARD;
            lane_reg   <= 2'd1;
            speed_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            flags_reg  <= flags_next;
            mode_reg   <= mode_next;
            lane_reg   <= lane_next;
            speed_reg  <= speed_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload capture and the pp*speed product (6x16, registered).
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            os_reg <= obj_s;
            es_reg <= ego_s;
            d_reg  <= obj_d;
            ed_reg <= ego_d;
            vx_reg <= obj_vx;
            vy_reg <= obj_vy;
            pp_reg <= path_points;
        end
        acc_reg  <= acc_next;
        proj_reg <= proj_next;
        if (sq_done)
            prod_reg <= 32'(pp_reg) * 32'(sq_root);
    end

    assign out_valid = ovalid_reg;
    assign mode      = mode_reg;
    assign lane      = lane_reg;
    assign ref_speed = speed_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane change planner testbench
// Drives frames of vehicle reports closed by decide items, predicts the mode,
// lane and reference speed of each decision, and compares them field by field.
// ----------------------------------------------------------------------------
module tb;
    import lcbp_pkg::*;

    // Clock, reset and block ports.
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [22:0] obj_s;
    logic signed [13:0] obj_d;
    logic signed [15:0] obj_vx;
    logic signed [15:0] obj_vy;
    logic [22:0] ego_s;
    logic signed [13:0] ego_d;
    logic [5:0]  path_points;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  mode;
    logic [1:0]  lane;
    logic [15:0] ref_speed;
    logic        cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  lane;
        logic [15:0] speed;
    } decision_t;

    // Predictor state and register copies.
    logic [15:0] p_front_gap, p_rear_gap, p_side_rear_gap, p_ahead_gap;
    logic [15:0] p_target, p_min;
    logic [11:0] p_step;
    logic [9:0]  p_center_tol;
    logic [9:0]  p_flags;
    logic [2:0]  p_mode;
    logic [1:0]  p_lane;
    logic [31:0] p_speed;

    decision_t decisions_due[$];
    int  errors;
    int  idle_pct;
    bit  hold_out;
    bit  hold_request;
    int  quiet_cycles;

    lane_change_behaviour_planner_unit DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Initial register values and state after reset.
    task automatic predictor_reset();
        p_front_gap = 16'd7680; p_rear_gap = 16'd1280; p_side_rear_gap = 16'd512;
        p_ahead_gap = 16'd12800; p_target = 16'd49500; p_min = 16'd10000;
        p_step = 12'd224; p_center_tol = 10'd26;
        p_flags = '0; p_mode = MODE_FORWARD; p_lane = 2'd1; p_speed = 0;
    endtask

    function automatic longint floor_sqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic bit lane_holds(longint d, longint k);
        return d > 1024 * k && d < 1024 * k + 1024;
    endfunction

    function automatic void accelerate();
        if (p_speed < p_target)
        begin
            p_speed = p_speed + p_step;
            if (p_speed > 65535) p_speed = 65535;
        end
    endfunction

    function automatic void decelerate();
        if (p_speed > p_min)
            p_speed = (p_speed > p_step) ? p_speed - p_step : 0;
    endfunction

    // Update the occupancy flags from one vehicle report.
    function automatic void track_vehicle(logic [22:0] os, logic signed [13:0] od,
                                          logic signed [15:0] vx, logic signed [15:0] vy,
                                          logic [22:0] es_in, logic [5:0] pp);
        longint spd, ps, es, cur, d;
        bit near_ahead, side;
        spd = floor_sqrt(longint'(vx) * vx + longint'(vy) * vy);
        ps = longint'(os) + (longint'(pp) * spd) / 50;
        es = es_in;
        cur = p_lane;
        d = od;
        near_ahead = ps > es && ps - es < p_front_gap;
        side = near_ahead || (ps <= es && es - ps < p_side_rear_gap);
        if (lane_holds(d, cur))
        begin
            if (near_ahead) p_flags[0] = 1'b1;
            else if (ps < es && es - ps < p_rear_gap) p_flags[1] = 1'b1;
        end
        else if (lane_holds(d, cur - 1))
        begin
            if (side) p_flags[2] = 1'b1;
        end
        else if (lane_holds(d, cur + 1))
        begin
            if (side) p_flags[3] = 1'b1;
        end
        for (int k = 0; k < 3; k++)
            if (lane_holds(d, k) && ps > es)
            begin
                if (ps - es < p_ahead_gap) p_flags[4 + k] = 1'b1;
                if (ps - es < p_front_gap) p_flags[7 + k] = 1'b1;
            end
    endfunction

    // Run the lane change machine on the gathered flags.
    function automatic decision_t plan_decision(logic signed [13:0] ed_in);
        decision_t r;
        bit front, back, left, right, centered, blocked, busy;
        longint off;
        logic [1:0] ln;
        front = p_flags[0]; back = p_flags[1]; left = p_flags[2]; right = p_flags[3];
        ln = p_lane;
        off = longint'(ed_in) - (512 + 1024 * longint'(ln));
        centered = ((off < 0) ? -off : off) < p_center_tol;
        case (p_mode)
            MODE_PREP_LEFT, MODE_PREP_RIGHT:
            begin
                blocked = (p_mode == MODE_PREP_LEFT) ? left : right;
                if (blocked)
                begin
                    if (back && !front) accelerate();
                    else decelerate();
                end
                else if (p_mode == MODE_PREP_LEFT)
                begin
                    if (p_lane > 2'd0) p_lane = p_lane - 2'd1;
                    p_mode = MODE_CHG_LEFT;
                end
                else
                begin
                    if (p_lane < 2'd2) p_lane = p_lane + 2'd1;
                    p_mode = MODE_CHG_RIGHT;
                end
            end
            MODE_CHG_LEFT, MODE_CHG_RIGHT:
            begin
                if (centered) p_mode = MODE_FORWARD;
                if (front) decelerate();
                else accelerate();
            end
            default:
            begin
                p_mode = MODE_FORWARD;
                if (!front)
                    accelerate();
                else if (ln > 0 && !left)
                begin
                    busy = p_flags[4 + ln - 1];
                    p_mode = (right || !busy || ln == 2) ? MODE_PREP_LEFT : MODE_PREP_RIGHT;
                end
                else if (ln < 2 && !right)
                begin
                    busy = p_flags[4 + ln + 1];
                    p_mode = (left || !busy || ln == 0) ? MODE_PREP_RIGHT : MODE_PREP_LEFT;
                end
                else
                begin
                    if (!back) decelerate();
                    if (ln == 0 && p_flags[9]) p_mode = MODE_PREP_RIGHT;
                    else if (ln == 2 && p_flags[7]) p_mode = MODE_PREP_LEFT;
                end
            end
        endcase
        p_flags = '0;
        r.mode = p_mode;
        r.lane = p_lane;
        r.speed = p_speed[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Send one item and hold it until accepted; valid drops only while idling.
    task automatic send_item(bit f, logic [22:0] os, logic signed [13:0] od,
                             logic signed [15:0] vx, logic signed [15:0] vy,
                             logic [22:0] es, logic signed [13:0] ed, logic [5:0] pp);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func <= f; obj_s <= os; obj_d <= od; obj_vx <= vx; obj_vy <= vy;
        ego_s <= es; ego_d <= ed; path_points <= pp;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (f) decisions_due.insert(decisions_due.size(), plan_decision(ed));
        else track_vehicle(os, od, vx, vy, es, pp);
    endtask

    task automatic send_vehicle(logic [22:0] os, logic signed [13:0] od,
                                logic signed [15:0] vx, logic signed [15:0] vy,
                                logic [22:0] es, logic [5:0] pp);
        send_item(1'b0, os, od, vx, vy, es, 14'($urandom), pp);
    endtask

    task automatic send_decide(logic signed [13:0] ed);
        send_item(1'b1, 23'($urandom), 14'($urandom), 16'($urandom), 16'($urandom),
                  23'($urandom), ed, 6'($urandom));
    endtask

    // Wait for all decisions to arrive and the block to go quiet.
    task automatic drain();
        in_valid <= 1'b0;
        while (decisions_due.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [15:0] value);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_FRONT_GAP:     p_front_gap = value;
            CFG_REAR_GAP:      p_rear_gap = value;
            CFG_SIDE_REAR_GAP: p_side_rear_gap = value;
            CFG_AHEAD_GAP:     p_ahead_gap = value;
            CFG_TARGET_SPEED:  p_target = value;
            CFG_MIN_SPEED:     p_min = value;
            CFG_SPEED_STEP:    p_step = value[11:0];
            default:           p_center_tol = value[9:0];
        endcase
    endtask

    // A vehicle near ego in a lane close to the current one.
    task automatic send_near_vehicle(logic [22:0] es);
        int ln;
        int dl;
        ln = int'(p_lane) + int'($urandom_range(2)) - 1;
        dl = $urandom_range(1, 1023);
        if ($urandom_range(9) == 0) dl = 0;
        send_vehicle(23'(int'(es) + int'($urandom_range(20000)) - 8000),
                     14'(ln * 1024 + dl),
                     16'(int'($urandom_range(12000)) - 6000),
                     16'(int'($urandom_range(2000)) - 1000),
                     es, 6'($urandom_range(50)));
    endtask

    // A decide with ego near or away from the target lane center.
    task automatic send_steered_decide();
        int c;
        c = 512 + 1024 * int'(p_lane);
        if ($urandom_range(3) != 0) send_decide(14'(c + int'($urandom_range(60)) - 30));
        else send_decide(14'($urandom));
    endtask

    task automatic test_directed();
        // Decide with no reports, field extremes, and edge projections.
        send_decide(14'sd1536);
        send_vehicle(23'h7FFFFF, 14'sh1FFF, 16'sh8000, 16'sh8000, 23'h7FFFFF, 6'd63);
        send_vehicle(23'd0, 14'sh2000, 16'sh7FFF, 16'sh7FFF, 23'd0, 6'd0);
        send_decide(14'sh2000);
        send_decide(14'sh1FFF);
        // Vehicle just ahead in own lane drives into prepare and change.
        send_vehicle(23'd100000, 14'sd1536, 16'sd0, 16'sd0, 23'd99000, 6'd50);
        send_decide(14'sd1536);
        send_decide(14'sd1536);
        send_decide(14'sd500);
        send_decide(14'sd500);
        // Left-blocked lane 0 with lane 2 close ahead, lane edges.
        send_vehicle(23'd100000, 14'sd512, 16'sd0, 16'sd0, 23'd99000, 6'd10);
        send_vehicle(23'd99800, 14'sd1536, 16'sd0, 16'sd0, 23'd99000, 6'd10);
        send_vehicle(23'd98900, 14'sd1536, 16'sd0, 16'sd0, 23'd99000, 6'd10);
        send_vehicle(23'd99500, 14'sd2560, 16'sd300, 16'sd0, 23'd99000, 6'd2);
        send_vehicle(23'd99000, 14'sd1024, 16'sd0, 16'sd0, 23'd99000, 6'd1);
        send_vehicle(23'd99000, -14'sd100, 16'sd0, 16'sd0, 23'd99000, 6'd1);
        send_decide(14'sd512);
        send_decide(14'sd512);
        send_decide(14'sd512);
        drain();
    endtask

    task automatic test_random_frames(int n_items);
        int sent;
        logic [22:0] es;
        sent = 0;
        while (sent < n_items)
        begin
            es = 23'($urandom_range(23'h7F0000, 23'd20000));
            if ($urandom_range(9) == 0)
            begin
                send_item(1'($urandom), 23'($urandom), 14'($urandom), 16'($urandom),
                          16'($urandom), 23'($urandom), 14'($urandom), 6'($urandom));
                sent++;
            end
            else
            begin
                repeat ($urandom_range(5))
                begin
                    send_near_vehicle(es);
                    sent++;
                end
                send_steered_decide();
                sent++;
            end
        end
        drain();
    endtask

    task automatic test_registers();
        write_reg(CFG_FRONT_GAP, 16'hFFFF);
        write_reg(CFG_REAR_GAP, 16'hFFFF);
        write_reg(CFG_SIDE_REAR_GAP, 16'hFFFF);
        write_reg(CFG_AHEAD_GAP, 16'hFFFF);
        write_reg(CFG_TARGET_SPEED, 16'hFFFF);
        write_reg(CFG_MIN_SPEED, 16'h0000);
        write_reg(CFG_SPEED_STEP, 16'h0FFF);
        write_reg(CFG_CENTER_TOL, 16'h03FF);
        test_random_frames(250);
        write_reg(CFG_FRONT_GAP, 16'd0);
        write_reg(CFG_REAR_GAP, 16'd0);
        write_reg(CFG_SIDE_REAR_GAP, 16'd0);
        write_reg(CFG_AHEAD_GAP, 16'd0);
        write_reg(CFG_TARGET_SPEED, 16'd0);
        write_reg(CFG_MIN_SPEED, 16'hFFFF);
        write_reg(CFG_SPEED_STEP, 16'd0);
        write_reg(CFG_CENTER_TOL, 16'd0);
        test_random_frames(120);
        write_reg(CFG_FRONT_GAP, 16'd3000);
        write_reg(CFG_REAR_GAP, 16'd2000);
        write_reg(CFG_SIDE_REAR_GAP, 16'd1500);
        write_reg(CFG_AHEAD_GAP, 16'd6000);
        write_reg(CFG_TARGET_SPEED, 16'd60000);
        write_reg(CFG_MIN_SPEED, 16'd3000);
        write_reg(CFG_SPEED_STEP, 16'd1500);
        write_reg(CFG_CENTER_TOL, 16'd200);
        test_random_frames(350);
    endtask

    task automatic test_back_pressure();
        hold_request = 1'b1;
        test_random_frames(40);
        hold_request = 1'b0;
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        test_random_frames(150);
        idle_pct = 23;
    endtask

    // Receiver stalls, with a long hold when requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_out)
            begin
                hold_out = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Compare each accepted result with the oldest decision.
    initial
    begin
        decision_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (decisions_due.size() == 0)
                    report_mismatch("unexpected result, mode", mode, -1);
                else
                begin
                    want = decisions_due.pop_front();
                    if (mode !== want.mode) report_mismatch("mode", mode, want.mode);
                    if (lane !== want.lane) report_mismatch("lane", lane, want.lane);
                    if (ref_speed !== want.speed)
                        report_mismatch("ref_speed", ref_speed, want.speed);
                end
            end
        end
    end

    // Watchdog on cycles with nothing accepted.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles > 20000)
            begin
                $display("lane_change_behaviour_planner_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0; idle_pct = 23; hold_out = 0; hold_request = 0;
        rst_n = 1'b0; in_valid = 1'b0; func = 1'b0; obj_s = '0; obj_d = '0;
        obj_vx = '0; obj_vy = '0; ego_s = '0; ego_d = '0; path_points = '0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        predictor_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_frames(350);
        test_back_pressure();
        test_no_idle();
        test_registers();
        drain();
        if (errors == 0)
            $display("lane_change_behaviour_planner_unit: match");
        else
            $display("lane_change_behaviour_planner_unit: mismatch");
        $finish;
    end
endmodule
